// ===== rtl/core/scrp_pkg.sv =====
// shared types, opcodes and register addresses for the spi register port of the can controller
package scrp_pkg;

    // register address space
    localparam int ADDR_W    = 7;
    localparam int REG_DEPTH = 1 << ADDR_W;

    typedef logic [ADDR_W-1:0] t_addr;

    // instruction opcodes
    localparam logic [7:0] OP_RESET  = 8'hC0;
    localparam logic [7:0] OP_WRITE  = 8'h02;
    localparam logic [7:0] OP_READ   = 8'h03;
    localparam logic [7:0] OP_MODIFY = 8'h05;
    localparam logic [7:0] OP_STATUS = 8'hA0;
    localparam logic [7:0] OP_RTS0   = 8'h81;

    // registers with special behavior
    localparam t_addr A_CANSTAT  = t_addr'(8'h0E);
    localparam t_addr A_CANCTRL  = t_addr'(8'h0F);
    localparam t_addr A_CANINTF  = t_addr'(8'h2C);
    localparam t_addr A_TXB0CTRL = t_addr'(8'h30);

    // mode field lives in bits 7..5, configuration mode after reset
    localparam logic [7:0] MODE_CONFIG = 8'h80;
    localparam int         TXREQ_POS   = 3;
    localparam int         RX0IF_POS   = 0;

    // position within a transaction
    typedef enum logic [1:0] {
        PH_ADDR,
        PH_MASK,
        PH_DATA,
        PH_DONE
    } t_phase;

endpackage

// ===== rtl/core/spi_can_controller_register_port.sv =====
// spi slave register port of a can controller: instruction decode, register file, status
//
//   channel   signals                                   payload
//   request   i_req_valid / o_req_ready                 i_mosi_byte, i_first_byte
//   response  o_rsp_valid / i_rsp_ready                 o_miso_byte
//
// one request per cycle while o_req_ready is high; each request yields one registered response.
// the register file ram is read ahead at the next address pointer,
// with a bypass for a write to that same address, so reads never stall.
// synchronous reset (and the reset instruction) clear per-entry valid bits at once;
// an entry never written since reads as zero, so no clearing pass is needed.
// o_req_ready is low while reset is held and while the skid entry holds a response.
// a two-deep response buffer keeps requests flowing while one response waits.
module spi_can_controller_register_port (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    input  logic [7:0] i_mosi_byte,
    input  logic       i_first_byte,
    output logic       o_rsp_valid,
    input  logic       i_rsp_ready,
    output logic [7:0] o_miso_byte
);

    // transaction state
    logic [7:0]                    r_instr, n_instr;
    scrp_pkg::t_phase              r_phase, n_phase;
    scrp_pkg::t_addr               r_ptr, n_ptr;
    logic [7:0]                    r_mask, n_mask;

    // registers kept in flops
    logic [2:0]                    r_canstat, n_canstat;
    logic [7:0]                    r_canctrl, n_canctrl;
    logic [7:0]                    r_canintf, n_canintf;
    logic [7:0]                    r_txb0ctrl, n_txb0ctrl;

    // register file ram bookkeeping
    logic [scrp_pkg::REG_DEPTH-1:0] r_valid, n_valid;
    logic                          r_byp_hit;
    logic [7:0]                    r_byp_data;
    logic [7:0]                    w_ram_q;
    logic                          w_ram_we;

    // response buffer
    logic                          r_out_valid;
    logic [7:0]                    r_out_data;
    logic                          r_skid_valid;
    logic [7:0]                    r_skid_data;

    logic                          w_acc;
    logic                          w_take;
    logic [7:0]                    w_ram_val;
    logic [7:0]                    w_cur;
    logic                          w_we;
    logic [7:0]                    w_wdata;
    logic [7:0]                    w_result;

    assign o_req_ready = i_rst_n && !r_skid_valid;
    assign w_acc       = i_req_valid && o_req_ready;
    assign w_take      = r_out_valid && i_rsp_ready;
    assign o_rsp_valid = r_out_valid;
    assign o_miso_byte = r_out_data;

    // ram holding the ordinary registers
    scrp_ram #(
        .WIDTH (8),
        .DEPTH (scrp_pkg::REG_DEPTH)
    ) u_regs (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_ptr),
        .i_wdata (w_wdata),
        .i_raddr (n_ptr),
        .o_rdata (w_ram_q)
    );

    // current register value at the address pointer
    always_comb begin
        if (r_byp_hit) begin
            w_ram_val = r_byp_data;
        end else if (r_valid[r_ptr]) begin
            w_ram_val = w_ram_q;
        end else begin
            w_ram_val = 8'h00;
        end
        case (r_ptr)
            scrp_pkg::A_CANSTAT:  w_cur = {r_canstat, 5'b0};
            scrp_pkg::A_CANCTRL:  w_cur = r_canctrl;
            scrp_pkg::A_CANINTF:  w_cur = r_canintf;
            scrp_pkg::A_TXB0CTRL: w_cur = r_txb0ctrl;
            default:              w_cur = w_ram_val;
        endcase
    end

    // store request and response byte for this request
    always_comb begin
        w_we     = 1'b0;
        w_wdata  = i_mosi_byte;
        w_result = 8'h00;
        if (w_acc && !i_first_byte) begin
            case (r_instr)
                scrp_pkg::OP_WRITE: begin
                    w_we = (r_phase != scrp_pkg::PH_ADDR);
                end
                scrp_pkg::OP_READ: begin
                    if (r_phase != scrp_pkg::PH_ADDR) begin
                        w_result = w_cur;
                    end
                end
                scrp_pkg::OP_MODIFY: begin
                    if (r_phase == scrp_pkg::PH_DATA) begin
                        w_we    = 1'b1;
                        w_wdata = (w_cur & ~r_mask) | (i_mosi_byte & r_mask);
                    end
                end
                scrp_pkg::OP_STATUS: begin
                    w_result = {5'b0, r_txb0ctrl[scrp_pkg::TXREQ_POS], 1'b0,
                                r_canintf[scrp_pkg::RX0IF_POS]};
                end
                default: begin
                    w_result = 8'h00;
                end
            endcase
        end
    end

    // canstat is read-only
    assign w_ram_we = w_we && (r_ptr != scrp_pkg::A_CANSTAT);

    // next transaction and register state
    always_comb begin
        n_instr    = r_instr;
        n_phase    = r_phase;
        n_ptr      = r_ptr;
        n_mask     = r_mask;
        n_canstat  = r_canstat;
        n_canctrl  = r_canctrl;
        n_canintf  = r_canintf;
        n_txb0ctrl = r_txb0ctrl;
        n_valid    = r_valid;
        if (w_acc && i_first_byte) begin
            n_instr = i_mosi_byte;
            n_phase = scrp_pkg::PH_ADDR;
            if (i_mosi_byte == scrp_pkg::OP_RESET) begin
                n_valid    = '0;
                n_canstat  = scrp_pkg::MODE_CONFIG[7:5];
                n_canctrl  = scrp_pkg::MODE_CONFIG;
                n_canintf  = 8'h00;
                n_txb0ctrl = 8'h00;
                n_ptr      = '0;
                n_mask     = 8'h00;
            end else if (i_mosi_byte == scrp_pkg::OP_RTS0) begin
                n_txb0ctrl[scrp_pkg::TXREQ_POS] = 1'b1;
            end
        end else if (w_acc) begin
            case (r_instr)
                scrp_pkg::OP_WRITE, scrp_pkg::OP_READ: begin
                    if (r_phase == scrp_pkg::PH_ADDR) begin
                        n_ptr   = i_mosi_byte[scrp_pkg::ADDR_W-1:0];
                        n_phase = scrp_pkg::PH_DATA;
                    end else begin
                        n_ptr = r_ptr + 1'b1;
                    end
                end
                scrp_pkg::OP_MODIFY: begin
                    case (r_phase)
                        scrp_pkg::PH_ADDR: begin
                            n_ptr   = i_mosi_byte[scrp_pkg::ADDR_W-1:0];
                            n_phase = scrp_pkg::PH_MASK;
                        end
                        scrp_pkg::PH_MASK: begin
                            n_mask  = i_mosi_byte;
                            n_phase = scrp_pkg::PH_DATA;
                        end
                        scrp_pkg::PH_DATA: begin
                            n_phase = scrp_pkg::PH_DONE;
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
            // register side effects of a store
            if (w_ram_we) begin
                n_valid[r_ptr] = 1'b1;
                case (r_ptr)
                    scrp_pkg::A_CANCTRL: begin
                        n_canctrl = w_wdata;
                        n_canstat = w_wdata[7:5];
                    end
                    scrp_pkg::A_CANINTF:  n_canintf  = w_wdata;
                    scrp_pkg::A_TXB0CTRL: n_txb0ctrl = w_wdata;
                    default:              n_canintf  = n_canintf;
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_instr    <= 8'h00;
            r_phase    <= scrp_pkg::PH_ADDR;
            r_ptr      <= '0;
            r_mask     <= 8'h00;
            r_canstat  <= scrp_pkg::MODE_CONFIG[7:5];
            r_canctrl  <= scrp_pkg::MODE_CONFIG;
            r_canintf  <= 8'h00;
            r_txb0ctrl <= 8'h00;
            r_valid    <= '0;
            r_byp_hit  <= 1'b0;
        end else begin
            r_instr    <= n_instr;
            r_phase    <= n_phase;
            r_ptr      <= n_ptr;
            r_mask     <= n_mask;
            r_canstat  <= n_canstat;
            r_canctrl  <= n_canctrl;
            r_canintf  <= n_canintf;
            r_txb0ctrl <= n_txb0ctrl;
            r_valid    <= n_valid;
            r_byp_hit  <= w_ram_we && (r_ptr == n_ptr);
        end
    end

    // bypass data for a write that collides with the prefetch
    always_ff @(posedge i_clk) begin
        r_byp_data <= w_wdata;
    end

    // response buffer: output register plus one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_acc;
            end
        end else if (w_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else begin
                r_out_data <= w_result;
            end
        end else if (w_acc) begin
            r_skid_data <= w_result;
        end
    end

endmodule

// ===== rtl/core/scrp_ram.sv =====
// generic single write port ram with registered read
module scrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read (old data on collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
